// File: hw/rtl/lws_pkg.sv
// ----------------------------------------------------------------------------
// lws_pkg
// Shared types and constants of the lookahead waypoint search block.
// ----------------------------------------------------------------------------
package lws_pkg;

  localparam int unsigned MAX_WAYPOINTS_DEF = 256;
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  localparam logic [30:0] FIXED_LOOKAHEAD_RST = 31'd65536;
  localparam logic [15:0] FIXED_SPEED_RST = 16'd512;

  typedef enum logic [1:0] {
    REG_FIXED_LOOKAHEAD = 2'd0,
    REG_FIXED_SPEED     = 2'd1,
    REG_USE_TABLE_LA    = 2'd2,
    REG_USE_TABLE_SPEED = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WALK,
    B_SQRT,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] wp_x;
    logic signed [31:0] wp_y;
    logic        [15:0] wp_speed;
    logic        [30:0] wp_lookahead;
    logic        [15:0] wp_gain;
    logic signed [15:0] rot_xx;
    logic signed [15:0] rot_xy;
    logic signed [15:0] rot_yx;
    logic signed [15:0] rot_yy;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
  } in_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic        [30:0] distance;
    logic        [15:0] gain;
    logic        [15:0] speed;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [15:0] speed;
    logic        [30:0] lookahead;
    logic        [15:0] gain;
  } wp_t;

  typedef struct packed {
    logic signed [15:0] rot_xx;
    logic signed [15:0] rot_xy;
    logic signed [15:0] rot_yx;
    logic signed [15:0] rot_yy;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
  } xform_t;

  typedef struct packed {
    logic [30:0] fixed_lookahead;
    logic [15:0] fixed_speed;
    logic        use_table_lookahead;
    logic        use_table_speed;
  } cfg_t;

endpackage

// File: hw/rtl/lookahead_waypoint_search.sv
// ----------------------------------------------------------------------------
// lookahead_waypoint_search
// Pure pursuit lookahead point search over a loaded waypoint table.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_push / in_full      | lws_pkg::in_t
//   out_    | output    | out_pop / out_empty    | lws_pkg::out_t
//   cfg_    | input     | APB psel/penable/pready| 32-bit registers
//
// A query leaving the query queue walks the table one entry per cycle from the
// single RAM read port; its word is posted once the transform pipeline drains,
// after a bit-serial square root when a point qualifies.
// Reset clears the table count and the queues; table entries are not cleared.
// A two-entry query queue lets loads and queries enter while the back end
// works or its result waits to be popped.
// ----------------------------------------------------------------------------
module lookahead_waypoint_search #(
  parameter int unsigned MAX_WAYPOINTS = lws_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  lws_pkg::in_t               in_data,
  output logic                       out_empty,
  input  logic                       out_pop,
  output lws_pkg::out_t              out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lws_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [lws_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [lws_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int unsigned AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);

  lws_pkg::cfg_t    cfg_r;
  lws_pkg::reg_idx_t ridx;
  logic             cfg_we;
  logic             wr_en, rd_en, q_valid, q_pop;
  logic [AW-1:0]    wr_addr, rd_addr;
  lws_pkg::wp_t     wr_data, rd_data;
  lws_pkg::xform_t  q_xform;
  logic [CW-1:0]    q_count;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign ridx       = lws_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fixed_lookahead     <= lws_pkg::FIXED_LOOKAHEAD_RST;
      cfg_r.fixed_speed         <= lws_pkg::FIXED_SPEED_RST;
      cfg_r.use_table_lookahead <= 1'b1;
      cfg_r.use_table_speed     <= 1'b0;
    end else if (cfg_we) begin
      case (ridx)
        lws_pkg::REG_FIXED_LOOKAHEAD: cfg_r.fixed_lookahead     <= cfg_pwdata[30:0];
        lws_pkg::REG_FIXED_SPEED:     cfg_r.fixed_speed         <= cfg_pwdata[15:0];
        lws_pkg::REG_USE_TABLE_LA:    cfg_r.use_table_lookahead <= cfg_pwdata[0];
        lws_pkg::REG_USE_TABLE_SPEED: cfg_r.use_table_speed     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      lws_pkg::REG_FIXED_LOOKAHEAD: cfg_prdata = {1'b0, cfg_r.fixed_lookahead};
      lws_pkg::REG_FIXED_SPEED:     cfg_prdata = {16'd0, cfg_r.fixed_speed};
      lws_pkg::REG_USE_TABLE_LA:    cfg_prdata = {31'd0, cfg_r.use_table_lookahead};
      lws_pkg::REG_USE_TABLE_SPEED: cfg_prdata = {31'd0, cfg_r.use_table_speed};
      default:                      cfg_prdata = '0;
    endcase
  end

  lws_front #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .q_valid (q_valid),
    .q_xform (q_xform),
    .q_count (q_count),
    .q_pop   (q_pop)
  );

  lws_ram #(.WIDTH($bits(lws_pkg::wp_t)), .DEPTH(MAX_WAYPOINTS)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lws_back #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_xform   (q_xform),
    .q_count   (q_count),
    .q_pop     (q_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/lws_ram.sv
// ----------------------------------------------------------------------------
// lws_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/lws_front.sv
// ----------------------------------------------------------------------------
// lws_front
// Accepts words, appends loads to the table, queues queries for the back end.
// ----------------------------------------------------------------------------
module lws_front #(
  parameter int unsigned MAX_WAYPOINTS = lws_pkg::MAX_WAYPOINTS_DEF,
  localparam int unsigned AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1,
  localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  lws_pkg::in_t    in_data,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output lws_pkg::wp_t    wr_data,
  output logic            q_valid,
  output lws_pkg::xform_t q_xform,
  output logic [CW-1:0]   q_count,
  input  logic            q_pop
);

  logic [CW-1:0]   cnt_r, cnt_nxt;
  lws_pkg::xform_t xf_r [2];
  logic [CW-1:0]   qc_r [2];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      fill_r, fill_nxt;
  logic            acc, push_q, is_load;

  assign in_full = (fill_r == 2'd2);
  assign acc     = in_push && !in_full;
  assign is_load = (in_data.op == lws_pkg::OP_LOAD);
  assign push_q  = acc && !is_load;

  assign wr_en   = acc && is_load && (cnt_r < CW'(MAX_WAYPOINTS));
  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = '{x: in_data.wp_x, y: in_data.wp_y, speed: in_data.wp_speed,
                     lookahead: in_data.wp_lookahead, gain: in_data.wp_gain};

  assign q_valid = (fill_r != 2'd0);
  assign q_xform = xf_r[rp_r];
  assign q_count = qc_r[rp_r];

  always_comb begin
    cnt_nxt  = wr_en ? cnt_r + CW'(1) : cnt_r;
    wp_nxt   = push_q ? !wp_r : wp_r;
    rp_nxt   = q_pop ? !rp_r : rp_r;
    fill_nxt = fill_r + 2'(push_q) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      cnt_r  <= cnt_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      xf_r[wp_r] <= '{rot_xx: in_data.rot_xx, rot_xy: in_data.rot_xy,
                      rot_yx: in_data.rot_yx, rot_yy: in_data.rot_yy,
                      shift_x: in_data.shift_x, shift_y: in_data.shift_y};
      qc_r[wp_r] <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/lws_back.sv
// ----------------------------------------------------------------------------
// lws_back
// Walks the table for one query through a transform pipeline, tracks the
// nearest point beyond the lookahead, then takes its square root when one is found.
// ----------------------------------------------------------------------------
module lws_back #(
  parameter int unsigned MAX_WAYPOINTS = lws_pkg::MAX_WAYPOINTS_DEF,
  localparam int unsigned AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1,
  localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lws_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  lws_pkg::xform_t q_xform,
  input  logic [CW-1:0]   q_count,
  output logic            q_pop,
  output logic            rd_en,
  output logic [AW-1:0]   rd_addr,
  input  lws_pkg::wp_t    rd_data,
  output logic            out_empty,
  input  logic            out_pop,
  output lws_pkg::out_t   out_data
);

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (!v[35] && (|v[34:31])) r = 32'sh7fffffff;
    else if (v[35] && !(&v[34:31])) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  lws_pkg::back_state_t st_r, st_nxt;
  logic [CW-1:0]   idx_r, cnt_r;
  lws_pkg::xform_t xf_r;
  logic            issue, busy;

  logic               rv_r, av_r, bv_r, cv_r;
  logic signed [47:0] pxx_r, pxy_r, pyx_r, pyy_r;
  logic [61:0]        la_a_r, la_b_r, la_c_r;
  logic [15:0]        g_a_r, g_b_r, g_c_r, s_a_r, s_b_r, s_c_r;
  logic signed [48:0] sx, sy;
  logic signed [31:0] vx_nxt, vy_nxt, vx_b_r, vy_b_r, vx_c_r, vy_c_r;
  logic [62:0]        sqx_r, sqy_r;
  logic [63:0]        d2;
  logic               hit;

  logic               have_r;
  logic [63:0]        best_r;
  logic signed [31:0] bx_r, by_r;
  logic [15:0]        bg_r, bs_r;

  logic [63:0] n_r;
  logic [34:0] rem_r, rem_sh, trial;
  logic [31:0] root_r;
  logic [4:0]  step_r;

  logic          out_v_r, load_out;
  lws_pkg::out_t out_r;

  assign issue    = (st_r == lws_pkg::B_WALK) && (idx_r < cnt_r);
  assign busy     = rv_r || av_r || bv_r || cv_r;
  assign rd_en    = issue;
  assign rd_addr  = idx_r[AW-1:0];
  assign load_out = (st_r == lws_pkg::B_DONE) && !out_v_r;

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    case (st_r)
      lws_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          st_nxt = lws_pkg::B_WALK;
        end
      end
      lws_pkg::B_WALK: begin
        if (!issue && !busy) st_nxt = have_r ? lws_pkg::B_SQRT : lws_pkg::B_DONE;
      end
      lws_pkg::B_SQRT: begin
        if (step_r == 5'd31) st_nxt = lws_pkg::B_DONE;
      end
      lws_pkg::B_DONE: begin
        if (!out_v_r) st_nxt = lws_pkg::B_IDLE;
      end
      default: st_nxt = lws_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    sx = 49'(pxx_r) + 49'(pxy_r);
    sy = 49'(pyx_r) + 49'(pyy_r);
    vx_nxt = sat32(36'($signed(sx[48:14])) + 36'(xf_r.shift_x));
    vy_nxt = sat32(36'($signed(sy[48:14])) + 36'(xf_r.shift_y));
    d2  = 64'(sqx_r) + 64'(sqy_r);
    hit = !vx_c_r[31] && (d2 > 64'(la_c_r)) && (!have_r || (d2 < best_r));
    rem_sh = {rem_r[32:0], n_r[63:62]};
    trial  = {1'b0, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= lws_pkg::B_IDLE;
      rv_r    <= 1'b0;
      av_r    <= 1'b0;
      bv_r    <= 1'b0;
      cv_r    <= 1'b0;
      have_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rv_r <= issue;
      av_r <= rv_r;
      bv_r <= av_r;
      cv_r <= bv_r;
      if (q_pop) have_r <= 1'b0;
      else if (cv_r && hit) have_r <= 1'b1;
      if (load_out) out_v_r <= 1'b1;
      else if (out_pop) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      xf_r  <= q_xform;
      cnt_r <= q_count;
      idx_r <= '0;
    end else if (issue) begin
      idx_r <= idx_r + CW'(1);
    end
    pxx_r  <= 48'(xf_r.rot_xx * rd_data.x);
    pxy_r  <= 48'(xf_r.rot_xy * rd_data.y);
    pyx_r  <= 48'(xf_r.rot_yx * rd_data.x);
    pyy_r  <= 48'(xf_r.rot_yy * rd_data.y);
    la_a_r <= cfg.use_table_lookahead
              ? 62'(rd_data.lookahead) * 62'(rd_data.lookahead)
              : 62'(cfg.fixed_lookahead) * 62'(cfg.fixed_lookahead);
    g_a_r  <= rd_data.gain;
    s_a_r  <= cfg.use_table_speed ? rd_data.speed : cfg.fixed_speed;
    vx_b_r <= vx_nxt;
    vy_b_r <= vy_nxt;
    la_b_r <= la_a_r;
    g_b_r  <= g_a_r;
    s_b_r  <= s_a_r;
    sqx_r  <= 63'(vx_b_r * vx_b_r);
    sqy_r  <= 63'(vy_b_r * vy_b_r);
    vx_c_r <= vx_b_r;
    vy_c_r <= vy_b_r;
    la_c_r <= la_b_r;
    g_c_r  <= g_b_r;
    s_c_r  <= s_b_r;
    if (cv_r && hit) begin
      best_r <= d2;
      bx_r   <= vx_c_r;
      by_r   <= vy_c_r;
      bg_r   <= g_c_r;
      bs_r   <= s_c_r;
    end
    if (st_r == lws_pkg::B_WALK) begin
      n_r    <= best_r;
      rem_r  <= '0;
      root_r <= '0;
      step_r <= '0;
    end else if (st_r == lws_pkg::B_SQRT) begin
      n_r    <= {n_r[61:0], 2'b00};
      step_r <= step_r + 5'd1;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
    if (load_out) begin
      out_r.found    <= have_r;
      out_r.point_x  <= have_r ? bx_r : '0;
      out_r.point_y  <= have_r ? by_r : '0;
      out_r.distance <= !have_r ? '0 : (root_r[31] ? 31'h7fffffff : root_r[30:0]);
      out_r.gain     <= have_r ? bg_r : '0;
      out_r.speed    <= have_r ? bs_r : '0;
    end
  end

  assign out_empty = !out_v_r;
  assign out_data  = out_r;

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (idx_r < cnt_r))
    else $error("table read beyond query count");

  a_sqrt_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == lws_pkg::B_SQRT) |-> !busy)
    else $error("square root started with pipeline busy");

  a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (have_r && st_r == lws_pkg::B_SQRT) |-> (best_r != 64'd0))
    else $error("best distance zero while found");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_v_r && st_r == lws_pkg::B_IDLE))
    else $error("result not posted");

endmodule

// File: verif/lookahead_waypoint_search_tb.sv
// ----------------------------------------------------------------------------
// lookahead_waypoint_search_tb
// Self-checking bench for the lookahead waypoint search. Loads and queries are
// pushed through the input queue port with random gaps or in bursts; each
// accepted query is predicted against a local copy of the waypoint table and
// configuration, and every popped word is compared field by field. Configuration
// is rewritten between phases while the block is idle, extremes included.
// ----------------------------------------------------------------------------
module lookahead_waypoint_search_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = lws_pkg::MAX_WAYPOINTS_DEF;
  localparam int unsigned DRAIN_CYCLES = 400;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_push = 1'b0;
  logic                         in_full;
  lws_pkg::in_t                 in_data = '0;
  logic                         out_empty;
  logic                         out_pop = 1'b0;
  lws_pkg::out_t                out_data;
  logic                         cfg_psel = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite = 1'b0;
  logic [lws_pkg::CFG_AW-1:0]   cfg_paddr = '0;
  logic [lws_pkg::CFG_DW-1:0]   cfg_pwdata = '0;
  logic [lws_pkg::CFG_DW-1:0]   cfg_prdata;
  logic                         cfg_pready;

  lookahead_waypoint_search u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lws_pkg::wp_t  wp_mem [DEPTH];
  int            wp_count = 0;
  lws_pkg::cfg_t cur_cfg = '{lws_pkg::FIXED_LOOKAHEAD_RST, lws_pkg::FIXED_SPEED_RST,
                             1'b1, 1'b0};

  lws_pkg::in_t  pending_cmds [$];
  lws_pkg::out_t expected_hits [$];
  int   err_cnt = 0;
  int   acc_cnt = 0;
  int   drv_cnt = 0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   rx_hold_left = 0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;

  function automatic logic signed [31:0] to_vehicle(logic signed [15:0] ra,
      logic signed [15:0] rb, logic signed [31:0] px, logic signed [31:0] py,
      logic signed [31:0] shift);
    longint p;
    p = longint'(ra) * longint'(px) + longint'(rb) * longint'(py);
    p = (p >>> 14) + longint'(shift);
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic bit [63:0] floor_sqrt(bit [63:0] n);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic lws_pkg::out_t search_lookahead(lws_pkg::in_t q);
    lws_pkg::out_t best;
    bit [63:0] best_d2;
    bit [63:0] d2;
    bit [63:0] la;
    longint    sx;
    longint    sy;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    best = '0;
    best_d2 = 0;
    for (int i = 0; i < wp_count; i++) begin
      vx = to_vehicle(q.rot_xx, q.rot_xy, wp_mem[i].x, wp_mem[i].y, q.shift_x);
      vy = to_vehicle(q.rot_yx, q.rot_yy, wp_mem[i].x, wp_mem[i].y, q.shift_y);
      if (vx < 0) continue;
      sx = longint'(vx) * longint'(vx);
      sy = longint'(vy) * longint'(vy);
      d2 = 64'(sx) + 64'(sy);
      la = cur_cfg.use_table_lookahead ? 64'(wp_mem[i].lookahead)
                                       : 64'(cur_cfg.fixed_lookahead);
      if (d2 > la * la && (!best.found || d2 < best_d2)) begin
        best_d2 = d2;
        best.found = 1'b1;
        best.point_x = vx;
        best.point_y = vy;
        best.gain = wp_mem[i].gain;
        best.speed = cur_cfg.use_table_speed ? wp_mem[i].speed : cur_cfg.fixed_speed;
      end
    end
    if (best.found) begin
      d2 = floor_sqrt(best_d2);
      best.distance = (d2 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : d2[30:0];
    end
    return best;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, field, got, want);
    err_cnt++;
  endtask

  // input acceptance and prediction
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      acc_cnt++;
      if (in_data.op == lws_pkg::OP_LOAD) begin
        if (wp_count < DEPTH) begin
          wp_mem[wp_count] = '{in_data.wp_x, in_data.wp_y, in_data.wp_speed,
                               in_data.wp_lookahead, in_data.wp_gain};
          wp_count++;
        end
      end else begin
        expected_hits.insert(expected_hits.size(), search_lookahead(in_data));
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    lws_pkg::out_t want;
    if (rst_n && out_pop && !out_empty) begin
      rx_gap = rx_burst ? 0 : $urandom_range(0, 15);
      if (expected_hits.size() == 0) begin
        report("unexpected word", out_data.point_x, 32'd0);
      end else begin
        want = expected_hits.pop_front();
        if (out_data.found !== want.found) report("found", out_data.found, want.found);
        if (out_data.point_x !== want.point_x)
          report("point_x", out_data.point_x, want.point_x);
        if (out_data.point_y !== want.point_y)
          report("point_y", out_data.point_y, want.point_y);
        if (out_data.distance !== want.distance)
          report("distance", out_data.distance, want.distance);
        if (out_data.gain !== want.gain) report("gain", out_data.gain, want.gain);
        if (out_data.speed !== want.speed) report("speed", out_data.speed, want.speed);
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (in_push && acc_cnt < drv_cnt) begin
      in_push <= 1'b1;
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_push <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      in_data <= pending_cmds.pop_front();
      in_push <= 1'b1;
      drv_cnt++;
      tx_gap = tx_burst ? 0 : $urandom_range(0, 15);
    end else begin
      in_push <= 1'b0;
    end
  end

  // long receiver hold-off
  always @(negedge clk) begin
    if (rx_hold_left > 0) rx_hold_left--;
  end

  // pop driver
  always @(negedge clk) begin
    if (!rst_n || rx_hold_left > 0) begin
      out_pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic cfg_write(lws_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = lws_pkg::CFG_AW'({idx, 2'b00});
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (idx)
      lws_pkg::REG_FIXED_LOOKAHEAD: cur_cfg.fixed_lookahead = val[30:0];
      lws_pkg::REG_FIXED_SPEED:     cur_cfg.fixed_speed = val[15:0];
      lws_pkg::REG_USE_TABLE_LA:    cur_cfg.use_table_lookahead = val[0];
      lws_pkg::REG_USE_TABLE_SPEED: cur_cfg.use_table_speed = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || in_push || expected_hits.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic lws_pkg::in_t noise();
    lws_pkg::in_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom};
    return it;
  endfunction

  function automatic void add_load(logic [31:0] x, logic [31:0] y, logic [15:0] spd,
      logic [30:0] la, logic [15:0] g);
    lws_pkg::in_t it;
    it = noise();
    it.op = lws_pkg::OP_LOAD;
    it.wp_x = x;
    it.wp_y = y;
    it.wp_speed = spd;
    it.wp_lookahead = la;
    it.wp_gain = g;
    pending_cmds.insert(pending_cmds.size(), it);
  endfunction

  function automatic void add_query(logic [15:0] xx, logic [15:0] xy, logic [15:0] yx,
      logic [15:0] yy, logic [31:0] tx, logic [31:0] ty);
    lws_pkg::in_t it;
    it = noise();
    it.op = lws_pkg::OP_QUERY;
    it.rot_xx = xx;
    it.rot_xy = xy;
    it.rot_yx = yx;
    it.rot_yy = yy;
    it.shift_x = tx;
    it.shift_y = ty;
    pending_cmds.insert(pending_cmds.size(), it);
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 200000000)) - 100000000);
      default: return 32'($signed($urandom_range(0, 2621440)) - 1310720);
    endcase
  endfunction

  function automatic logic [30:0] rand_la();
    case ($urandom_range(0, 3))
      0:       return 31'($urandom);
      1:       return 31'd0;
      default: return 31'($urandom_range(0, 655360));
    endcase
  endfunction

  function automatic void rand_query();
    real  a;
    logic [15:0] c;
    logic [15:0] s;
    if ($urandom_range(0, 3) == 0) begin
      add_query(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                rand_pos(), rand_pos());
    end else begin
      a = $urandom_range(0, 62831) / 10000.0;
      c = 16'($rtoi(16383.0 * $cos(a)));
      s = 16'($rtoi(16383.0 * $sin(a)));
      add_query(c, s, -s, c, rand_pos(), rand_pos());
    end
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_query(16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 32'd0, 32'd0);
    add_load(32'd65536, 32'd0, 16'h1234, 31'd65536, 16'd1);
    add_load(32'd196608, 32'd0, 16'hFFFF, 31'd0, 16'hFFFF);
    add_load(32'd196608, 32'd0, 16'h0001, 31'd0, 16'd7);
    add_load(-32'sd327680, 32'd0, 16'd3, 31'd10, 16'd3);
    add_load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 31'h7FFF_FFFF, 16'd0);
    add_load(32'h8000_0000, 32'h8000_0000, 16'd9, 31'd0, 16'h8000);
    add_query(16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 32'd0, 32'd0);
    add_query(-16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 32'd0, 32'd0);
    add_query(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_query(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0000, 32'h8000_0000);
    add_query(16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_query(16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd0, 32'd0);
    add_query(16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h8000_0000, 32'h0000_FFFF);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          cfg_write(lws_pkg::REG_FIXED_LOOKAHEAD, 32'd0);
          cfg_write(lws_pkg::REG_FIXED_SPEED, 32'd0);
          cfg_write(lws_pkg::REG_USE_TABLE_LA, 32'd0);
          cfg_write(lws_pkg::REG_USE_TABLE_SPEED, 32'd0);
        end
        1: begin
          cfg_write(lws_pkg::REG_FIXED_LOOKAHEAD, 32'h7FFF_FFFF);
          cfg_write(lws_pkg::REG_FIXED_SPEED, 32'hFFFF);
          cfg_write(lws_pkg::REG_USE_TABLE_LA, 32'd1);
          cfg_write(lws_pkg::REG_USE_TABLE_SPEED, 32'd1);
        end
        default: begin
          cfg_write(lws_pkg::REG_FIXED_LOOKAHEAD,
                    ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 655360));
          cfg_write(lws_pkg::REG_FIXED_SPEED, $urandom);
          cfg_write(lws_pkg::REG_USE_TABLE_LA, $urandom);
          cfg_write(lws_pkg::REG_USE_TABLE_SPEED, $urandom);
        end
      endcase
      tx_burst = (ph % 3 == 1);
      rx_burst = (ph % 4 == 2);
      for (int k = 0; k < 217; k++) begin
        if ($urandom_range(0, 234) < 45)
          add_load(rand_pos(), rand_pos(), 16'($urandom), rand_la(), 16'($urandom));
        else
          rand_query();
      end
      if (ph == 2) begin
        while (pending_cmds.size() > 200) @(posedge clk);
        rx_hold_left = 3000;
      end
      wait_idle();
    end

    if (expected_hits.size() != 0) report("words left over", expected_hits.size(), 0);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
